// ===== rtl/channel_flow_source_term_defines.svh =====
// Assertion helpers for the channel flow source term RTL.
`ifndef CHANNEL_FLOW_SOURCE_TERM_DEFINES_SVH
`define CHANNEL_FLOW_SOURCE_TERM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cfst_pkg.sv =====
`default_nettype none

package cfst_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int AREA_W  = 31;
    localparam int FLOW_W  = 32;
    localparam int LEVEL_W = 32;
    localparam int ROUGH_W = 16;
    localparam int CFG_W   = 31;
    localparam int OUT_W   = 32;

    localparam int AREA_LSB  = 0;
    localparam int FLOW_LSB  = AREA_LSB + AREA_W;
    localparam int LEVEL_LSB = FLOW_LSB + FLOW_W;
    localparam int ROUGH_LSB = LEVEL_LSB + LEVEL_W;
    localparam int IN_BITS   = ROUGH_LSB + ROUGH_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_FRICTION_GAIN = 2'd0;
    localparam logic [1:0] REG_HALF_GRAVITY  = 2'd1;
    localparam logic [1:0] REG_INV_DX        = 2'd2;

    localparam logic [CFG_W-1:0] FRICTION_GAIN_RST = CFG_W'(238945);
    localparam logic [CFG_W-1:0] HALF_GRAVITY_RST  = CFG_W'(321454);
    localparam logic [CFG_W-1:0] INV_DX_RST        = CFG_W'(6554);

    // Widths of the fixed-point intermediates.
    localparam int MUL_W = 32;
    localparam int ACC_W = 127;
    localparam int FR_W  = ACC_W - 32;
    localparam int ASQ_W = 2 * AREA_W;

    localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NSQ,
        S_QSQ,
        S_GN,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_ASQ,
        S_DSTART,
        S_HG,
        S_DX,
        S_S0,
        S_S1,
        S_S2,
        S_S3,
        S_WAIT,
        S_SGN,
        S_DIFF,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_NSQ,
        MOP_QSQ,
        MOP_GN,
        MOP_F0,
        MOP_F1,
        MOP_F2,
        MOP_F3,
        MOP_ASQ,
        MOP_HG,
        MOP_DX,
        MOP_S0,
        MOP_S1,
        MOP_S2,
        MOP_S3
    } t_mop;

    typedef struct packed {
        logic load_start;
        logic capture;
        t_mop mop;
        logic div_start;
        logic sign_stage;
        logic diff_stage;
        logic load_out;
        logic central;
    } t_cmd;

    typedef struct packed {
        logic zero_area;
        logic div_busy;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/cfst_div.sv =====
`default_nettype none

module cfst_div
    import cfst_pkg::*;
#(
    parameter int NUM_W = FR_W,
    parameter int DEN_W = ASQ_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_W-1:0]      o_quo
);

    localparam int ITER  = (NUM_W + 1) / 2;
    localparam int PAD_W = 2 * ITER;
    localparam int CNT_W = $clog2(ITER + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [PAD_W-1:0] r_num;
    logic [PAD_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   t1;
    logic [DEN_W:0]   t2;
    logic [DEN_W-1:0] rem1;
    logic [DEN_W-1:0] rem2;
    logic             q1;
    logic             q2;

    // Two restoring steps per cycle.
    always_comb begin
        t1 = {r_rem, r_num[PAD_W-1]};
        q1 = (t1 >= {1'b0, r_den});
        rem1 = q1 ? DEN_W'(t1 - {1'b0, r_den}) : t1[DEN_W-1:0];
        t2 = {rem1, r_num[PAD_W-2]};
        q2 = (t2 >= {1'b0, r_den});
        rem2 = q2 ? DEN_W'(t2 - {1'b0, r_den}) : t2[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ITER);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= PAD_W'(i_num);
            r_quo <= '0;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[PAD_W-3:0], 2'b00};
            r_quo <= {r_quo[PAD_W-3:0], q1, q2};
            r_rem <= rem2;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo[NUM_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/cfst_dp.sv =====
`default_nettype none

module cfst_dp
    import cfst_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [AREA_W-1:0]  i_area,
    input  wire logic [FLOW_W-1:0]  i_discharge,
    input  wire logic [LEVEL_W-1:0] i_level,
    input  wire logic [ROUGH_W-1:0] i_roughness,
    input  wire logic               i_ghost,
    input  wire logic [CFG_W-1:0]   i_friction_gain,
    input  wire logic [CFG_W-1:0]   i_half_gravity,
    input  wire logic [CFG_W-1:0]   i_inv_dx,
    output t_sts                    o_sts,
    output logic [OUT_W-1:0]        o_source_term,
    output logic                    o_last_result,
    output logic                    o_zero_area
);

    localparam int SH   = 3 * FRAC_BITS;
    localparam int SL_W = ACC_W - SH;
    localparam int SW   = ((FR_W > SL_W) ? FR_W : SL_W) + 1;

    // Node window.
    logic [AREA_W-1:0]  r_area_back;
    logic [AREA_W-1:0]  r_area_mid;
    logic [FLOW_W-1:0]  r_flow_mid;
    logic [ROUGH_W-1:0] r_rough_mid;
    logic [LEVEL_W-1:0] r_level_back;
    logic [LEVEL_W-1:0] r_level_mid;

    // Node that closes the window.
    logic [AREA_W-1:0]  r_cur_area;
    logic [FLOW_W-1:0]  r_cur_flow;
    logic [LEVEL_W-1:0] r_cur_level;
    logic [ROUGH_W-1:0] r_cur_rough;
    logic               r_cur_ghost;

    logic [31:0]        r_nsq;
    logic [63:0]        r_qsq;
    logic [62:0]        r_g;
    logic [ASQ_W-1:0]   r_asq;
    logic [31:0]        r_asum;
    logic [31:0]        r_dh;
    logic               r_dh_neg;
    logic [62:0]        r_p1;
    logic [63:0]        r_p2;
    logic [ACC_W-1:0]   r_acc;
    logic [SW-1:0]      r_frs;
    logic [SW-1:0]      r_sls;
    logic [SW:0]        r_diff;

    logic [OUT_W-1:0]   r_source_term;
    logic               r_last_result;
    logic               r_zero_area;

    logic [MUL_W-1:0]   m_a;
    logic [MUL_W-1:0]   m_b;
    logic [2*MUL_W-1:0] m_p;
    logic               flow_neg;
    logic [FLOW_W-1:0]  flow_mag;
    logic [AREA_W-1:0]  area_left;
    logic [LEVEL_W-1:0] level_left;
    logic [LEVEL_W:0]   dh_full;
    logic [LEVEL_W:0]   dh_mag;
    logic [ACC_W-1:0]   sl_full;
    logic [SW-1:0]      fr_ext;
    logic [SW-1:0]      sl_ext;
    logic               fits;
    logic [OUT_W-1:0]   sat_val;
    logic [FR_W-1:0]    quo;
    logic               div_busy;
    logic               zero_area;

    assign flow_neg   = r_flow_mid[FLOW_W-1];
    assign flow_mag   = flow_neg ? (FLOW_W'(0) - r_flow_mid) : r_flow_mid;
    assign area_left  = i_cmd.central ? r_area_back : r_area_mid;
    assign level_left = i_cmd.central ? r_level_back : r_level_mid;
    assign dh_full    = {r_cur_level[LEVEL_W-1], r_cur_level}
                      - {level_left[LEVEL_W-1], level_left};
    assign dh_mag     = dh_full[LEVEL_W] ? ((LEVEL_W+1)'(0) - dh_full) : dh_full;
    assign zero_area  = (r_area_mid == '0);

    // Shared 32x32 multiplier; the operands follow the sequencer's step.
    always_comb begin
        unique case (i_cmd.mop)
            MOP_NSQ: begin
                m_a = MUL_W'(r_rough_mid);
                m_b = MUL_W'(r_rough_mid);
            end
            MOP_QSQ: begin
                m_a = flow_mag;
                m_b = flow_mag;
            end
            MOP_GN: begin
                m_a = MUL_W'(i_friction_gain);
                m_b = r_nsq;
            end
            MOP_F0: begin
                m_a = r_g[31:0];
                m_b = r_qsq[31:0];
            end
            MOP_F1: begin
                m_a = r_g[31:0];
                m_b = r_qsq[63:32];
            end
            MOP_F2: begin
                m_a = MUL_W'(r_g[62:32]);
                m_b = r_qsq[31:0];
            end
            MOP_F3: begin
                m_a = MUL_W'(r_g[62:32]);
                m_b = r_qsq[63:32];
            end
            MOP_ASQ: begin
                m_a = MUL_W'(r_area_mid);
                m_b = MUL_W'(r_area_mid);
            end
            MOP_HG: begin
                m_a = MUL_W'(i_half_gravity);
                m_b = r_asum;
            end
            MOP_DX: begin
                m_a = r_dh;
                m_b = MUL_W'(i_inv_dx);
            end
            MOP_S0: begin
                m_a = r_p1[31:0];
                m_b = r_p2[31:0];
            end
            MOP_S1: begin
                m_a = r_p1[31:0];
                m_b = r_p2[63:32];
            end
            MOP_S2: begin
                m_a = MUL_W'(r_p1[62:32]);
                m_b = r_p2[31:0];
            end
            MOP_S3: begin
                m_a = MUL_W'(r_p1[62:32]);
                m_b = r_p2[63:32];
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = (2*MUL_W)'(m_a) * (2*MUL_W)'(m_b);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.mop)
            MOP_NSQ: r_nsq <= m_p[31:0];
            MOP_QSQ: r_qsq <= m_p;
            MOP_GN:  r_g   <= m_p[62:0];
            MOP_ASQ: r_asq <= m_p[ASQ_W-1:0];
            MOP_HG:  r_p1  <= m_p[62:0];
            MOP_DX:  r_p2  <= m_p;
            MOP_F0, MOP_S0: r_acc <= ACC_W'(m_p);
            MOP_F1, MOP_F2, MOP_S1, MOP_S2: r_acc <= r_acc + (ACC_W'(m_p) << 32);
            MOP_F3, MOP_S3: r_acc <= r_acc + (ACC_W'(m_p) << 64);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_asum   <= 32'(area_left) + 32'(r_cur_area);
            r_dh     <= dh_mag[LEVEL_W-1:0];
            r_dh_neg <= dh_full[LEVEL_W];
        end
    end

    cfst_div #(
        .NUM_W (FR_W),
        .DEN_W (ASQ_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_acc[ACC_W-1:32]),
        .i_den   (r_asq),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    assign sl_full = i_cmd.central ? (r_acc >> (SH + 1)) : (r_acc >> SH);
    assign fr_ext  = SW'(quo);
    assign sl_ext  = SW'(sl_full[SL_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sign_stage) begin
            r_frs <= flow_neg ? (SW'(0) - fr_ext) : fr_ext;
            r_sls <= r_dh_neg ? (SW'(0) - sl_ext) : sl_ext;
        end
        if (i_cmd.diff_stage) begin
            r_diff <= {r_frs[SW-1], r_frs} - {r_sls[SW-1], r_sls};
        end
    end

    // The difference fits when every bit from bit 31 up equals the sign.
    assign fits    = (r_diff[SW:OUT_W-1] == '0) || (r_diff[SW:OUT_W-1] == '1);
    assign sat_val = fits ? r_diff[OUT_W-1:0] : (r_diff[SW] ? SAT_NEG : SAT_POS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_source_term <= zero_area ? (flow_neg ? SAT_NEG : SAT_POS) : sat_val;
            r_last_result <= r_cur_ghost;
            r_zero_area   <= zero_area;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_back  <= '0;
            r_area_mid   <= '0;
            r_flow_mid   <= '0;
            r_rough_mid  <= '0;
            r_level_back <= '0;
            r_level_mid  <= '0;
        end else if (i_cmd.load_start) begin
            r_area_back  <= '0;
            r_level_back <= '0;
            r_area_mid   <= i_area;
            r_flow_mid   <= i_discharge;
            r_rough_mid  <= i_roughness;
            r_level_mid  <= i_level;
        end else if (i_cmd.load_out) begin
            r_area_back  <= r_area_mid;
            r_level_back <= r_level_mid;
            r_area_mid   <= r_cur_area;
            r_flow_mid   <= r_cur_flow;
            r_rough_mid  <= r_cur_rough;
            r_level_mid  <= r_cur_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur_area  <= i_area;
            r_cur_flow  <= i_discharge;
            r_cur_level <= i_level;
            r_cur_rough <= i_roughness;
            r_cur_ghost <= i_ghost;
        end
    end

    assign o_sts.zero_area = zero_area;
    assign o_sts.div_busy  = div_busy;
    assign o_source_term   = r_source_term;
    assign o_last_result   = r_last_result;
    assign o_zero_area     = r_zero_area;

endmodule

`default_nettype wire

// ===== rtl/cfst_ctrl.sv =====
`default_nettype none
`include "channel_flow_source_term_defines.svh"

module cfst_ctrl
    import cfst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_first,
    input  wire logic i_in_ghost,
    output logic      o_in_ready,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_nodes_seen;
    logic [1:0] n_nodes_seen;
    logic       r_central;
    logic       n_central;
    logic       r_ghost;
    logic       n_ghost;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_nodes_seen <= 2'd0;
            r_central    <= 1'b0;
            r_ghost      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_nodes_seen <= n_nodes_seen;
            r_central    <= n_central;
            r_ghost      <= n_ghost;
            r_out_valid  <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_nodes_seen = r_nodes_seen;
        n_central    = r_central;
        n_ghost      = r_ghost;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd        = '0;
        o_cmd.mop    = MOP_NONE;
        o_cmd.central = r_central;
        o_in_ready   = (r_state == S_IDLE);
        accept       = o_in_ready && i_in_valid;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_first || (r_nodes_seen == 2'd0)) begin
                        o_cmd.load_start = 1'b1;
                        n_nodes_seen = i_in_ghost ? 2'd0 : 2'd1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_central = (r_nodes_seen >= 2'd2);
                        n_ghost   = i_in_ghost;
                        n_state   = i_sts.zero_area ? S_FIN : S_NSQ;
                    end
                end
            end
            S_NSQ: begin
                o_cmd.mop = MOP_NSQ;
                n_state = S_QSQ;
            end
            S_QSQ: begin
                o_cmd.mop = MOP_QSQ;
                n_state = S_GN;
            end
            S_GN: begin
                o_cmd.mop = MOP_GN;
                n_state = S_F0;
            end
            S_F0: begin
                o_cmd.mop = MOP_F0;
                n_state = S_F1;
            end
            S_F1: begin
                o_cmd.mop = MOP_F1;
                n_state = S_F2;
            end
            S_F2: begin
                o_cmd.mop = MOP_F2;
                n_state = S_F3;
            end
            S_F3: begin
                o_cmd.mop = MOP_F3;
                n_state = S_ASQ;
            end
            S_ASQ: begin
                o_cmd.mop = MOP_ASQ;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = S_HG;
            end
            S_HG: begin
                o_cmd.mop = MOP_HG;
                n_state = S_DX;
            end
            S_DX: begin
                o_cmd.mop = MOP_DX;
                n_state = S_S0;
            end
            S_S0: begin
                o_cmd.mop = MOP_S0;
                n_state = S_S1;
            end
            S_S1: begin
                o_cmd.mop = MOP_S1;
                n_state = S_S2;
            end
            S_S2: begin
                o_cmd.mop = MOP_S2;
                n_state = S_S3;
            end
            S_S3: begin
                o_cmd.mop = MOP_S3;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_SGN;
                end
            end
            S_SGN: begin
                o_cmd.sign_stage = 1'b1;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff_stage = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_nodes_seen = r_ghost ? 2'd0 : 2'd2;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `CFST_ASSERT_IMP(a_div_start_free, i_clk, i_rst_n, o_cmd.div_start, !i_sts.div_busy, "divider started while busy")
    `CFST_ASSERT_IMP(a_out_no_overwrite, i_clk, i_rst_n, o_cmd.load_out, !r_out_valid || i_out_ready, "pending word overwritten")
    `CFST_ASSERT_IMP(a_nodes_range, i_clk, i_rst_n, 1'b1, r_nodes_seen != 2'd3, "node count out of range")
    `CFST_ASSERT_NXT(a_ghost_closes_run, i_clk, i_rst_n, o_cmd.load_out && r_ghost, r_nodes_seen == 2'd0, "run not closed by ghost node")

endmodule

`default_nettype wire

// ===== rtl/channel_flow_source_term.sv =====
`default_nettype none

// Saint-Venant source term unit. River cross-section nodes stream in one word
// at a time (area, discharge, level, Manning roughness); tuser marks the first
// node of a run and tlast the ghost node that closes it. Each node after the
// first yields one output word for the node before it: Manning friction minus
// the level-slope term, saturated to signed Q16.16, with tlast copied from the
// input word that produced it and tuser set when that node's area was zero.
// A node that produces a result passes through the iterative divider, which
// retires two quotient bits per cycle over a 95-bit numerator, and the
// multiply steps on one shared 32x32 multiplier; a zero-area node skips both.
// Either is held while an earlier word still waits at the output. One result
// word can wait at the output while the next node is accepted. Registers
// friction_gain, half_gravity and inv_dx sit at byte addresses 0, 4 and 8
// and should only be written while the unit is idle.
module channel_flow_source_term
    import cfst_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // area[30:0], discharge[62:31], level[94:63], roughness[110:95], zero pad
    input  wire logic [IN_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                 i_s_axis_tlast,
    // first_node
    input  wire logic                 i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // source_term[31:0]
    output logic [OUT_W-1:0]          o_m_axis_tdata,
    output logic                      o_m_axis_tlast,
    // zero_area
    output logic                      o_m_axis_tuser,
    input  wire logic                 i_psel,
    input  wire logic                 i_penable,
    input  wire logic                 i_pwrite,
    input  wire logic [PADDR_W-1:0]   i_paddr,
    input  wire logic [PDATA_W-1:0]   i_pwdata,
    output logic [PDATA_W-1:0]        o_prdata,
    output logic                      o_pready
);

    logic [CFG_W-1:0] r_friction_gain;
    logic [CFG_W-1:0] r_half_gravity;
    logic [CFG_W-1:0] r_inv_dx;
    logic             cfg_write;
    logic [1:0]       cfg_index;
    t_cmd             cmd;
    t_sts             sts;

    assign o_pready  = 1'b1;
    assign cfg_write = i_psel && i_penable && i_pwrite;
    assign cfg_index = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_friction_gain <= FRICTION_GAIN_RST;
            r_half_gravity  <= HALF_GRAVITY_RST;
            r_inv_dx        <= INV_DX_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_FRICTION_GAIN: r_friction_gain <= i_pwdata[CFG_W-1:0];
                REG_HALF_GRAVITY:  r_half_gravity  <= i_pwdata[CFG_W-1:0];
                REG_INV_DX:        r_inv_dx        <= i_pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_FRICTION_GAIN: o_prdata = PDATA_W'(r_friction_gain);
            REG_HALF_GRAVITY:  o_prdata = PDATA_W'(r_half_gravity);
            REG_INV_DX:        o_prdata = PDATA_W'(r_inv_dx);
            default:           o_prdata = '0;
        endcase
    end

    cfst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_first  (i_s_axis_tuser),
        .i_in_ghost  (i_s_axis_tlast),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cfst_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_area          (i_s_axis_tdata[FLOW_LSB-1:AREA_LSB]),
        .i_discharge     (i_s_axis_tdata[LEVEL_LSB-1:FLOW_LSB]),
        .i_level         (i_s_axis_tdata[ROUGH_LSB-1:LEVEL_LSB]),
        .i_roughness     (i_s_axis_tdata[IN_BITS-1:ROUGH_LSB]),
        .i_ghost         (i_s_axis_tlast),
        .i_friction_gain (r_friction_gain),
        .i_half_gravity  (r_half_gravity),
        .i_inv_dx        (r_inv_dx),
        .o_sts           (sts),
        .o_source_term   (o_m_axis_tdata),
        .o_last_result   (o_m_axis_tlast),
        .o_zero_area     (o_m_axis_tuser)
    );

endmodule

`default_nettype wire
